[hdl/lps_pkg.sv]
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, constants and the sequencer's control store for the linear
// prime sieve.
// ----------------------------------------------------------------------------
package lps_pkg;

	// field widths of the channels
	localparam int NUM_W  = 13;
	localparam int CNT_W  = 11;
	localparam int STAT_W = 2;

	// default sizing
	localparam int MAX_NUMBER_DEF  = 4096;
	localparam int PRIME_SLOTS_DEF = 1024;

	// limit register after reset
	localparam logic [NUM_W-1:0] LIMIT_RESET = NUM_W'(4096);

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_ORDER = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	// sequencer steps
	typedef enum logic [2:0] {
		S_ACCEPT = 3'd0,
		S_CHECK  = 3'd1,
		S_SELF   = 3'd2,
		S_FETCH  = 3'd3,
		S_MUL    = 3'd4,
		S_MARK   = 3'd5,
		S_EMIT   = 3'd6
	} step_t;

	// datapath action of one step
	typedef enum logic [2:0] {
		ACT_ACCEPT = 3'd0,
		ACT_RD_SELF = 3'd1,
		ACT_SELF   = 3'd2,
		ACT_FETCH  = 3'd3,
		ACT_MUL    = 3'd4,
		ACT_MARK   = 3'd5,
		ACT_EMIT   = 3'd6,
		ACT_NOP    = 3'd7
	} act_t;

	// branch condition of one step
	typedef enum logic [2:0] {
		COND_NEVER   = 3'd0,
		COND_NO_TXN  = 3'd1,
		COND_ERR     = 3'd2,
		COND_KDONE   = 3'd3,
		COND_STOP    = 3'd4,
		COND_OUT_BSY = 3'd5
	} cond_t;

	// one control word
	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t on_true;
		step_t on_false;
	} uword_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic no_txn;
		logic err;
		logic kdone;
		logic stop;
		logic out_busy;
	} flags_t;

	// control store
	function automatic uword_t ucode_rom(input step_t step);
		uword_t w;
		case (step)
			S_ACCEPT: w = '{ACT_ACCEPT,  COND_NO_TXN,  S_ACCEPT, S_CHECK};
			S_CHECK:  w = '{ACT_RD_SELF, COND_ERR,     S_EMIT,   S_SELF};
			S_SELF:   w = '{ACT_SELF,    COND_NEVER,   S_FETCH,  S_FETCH};
			S_FETCH:  w = '{ACT_FETCH,   COND_KDONE,   S_EMIT,   S_MUL};
			S_MUL:    w = '{ACT_MUL,     COND_NEVER,   S_MARK,   S_MARK};
			S_MARK:   w = '{ACT_MARK,    COND_STOP,    S_EMIT,   S_FETCH};
			S_EMIT:   w = '{ACT_EMIT,    COND_OUT_BSY, S_EMIT,   S_ACCEPT};
			default:  w = '{ACT_NOP,     COND_NEVER,   S_ACCEPT, S_ACCEPT};
		endcase
		return w;
	endfunction

endpackage

[hdl/lps_if.sv]
// ----------------------------------------------------------------------------
// lps_if
// Valid/ready channels of the linear prime sieve: integer in, result out.
// ----------------------------------------------------------------------------
interface lps_in_if;
	import lps_pkg::*;

	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] number;

	modport source(output valid, output number, input ready);
	modport sink(input valid, input number, output ready);
endinterface

interface lps_out_if;
	import lps_pkg::*;

	logic              valid;
	logic              ready;
	logic [NUM_W-1:0]  smallest_factor;
	logic              is_prime;
	logic [CNT_W-1:0]  primes_found;
	logic [STAT_W-1:0] status;

	modport source(output valid, output smallest_factor, output is_prime,
		output primes_found, output status, input ready);
	modport sink(input valid, input smallest_factor, input is_prime,
		input primes_found, input status, output ready);
endinterface

[hdl/lps_ram.sv]
// ----------------------------------------------------------------------------
// lps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule

[hdl/lps_seq.sv]
// ----------------------------------------------------------------------------
// lps_seq
// Microcoded sequencer: step counter over the control store, two-way branch
// on one datapath flag per step.
// ----------------------------------------------------------------------------
module lps_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  lps_pkg::flags_t flags,
	output lps_pkg::act_t   act
);
	import lps_pkg::*;

	step_t  step_q;
	step_t  step_next;
	uword_t word;
	logic   taken;

	assign word = ucode_rom(step_q);

	// branch condition select and next step
	always_comb begin
		case (word.cond)
			COND_NEVER:   taken = 1'b0;
			COND_NO_TXN:  taken = flags.no_txn;
			COND_ERR:     taken = flags.err;
			COND_KDONE:   taken = flags.kdone;
			COND_STOP:    taken = flags.stop;
			COND_OUT_BSY: taken = flags.out_busy;
			default:      taken = 1'b0;
		endcase
		step_next = taken ? word.on_true : word.on_false;
	end

	// control word decode
	always_comb begin
		act = word.act;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_ACCEPT;
		end else begin
			step_q <= step_next;
		end
	end
endmodule

[hdl/linear_prime_sieve.sv]
// ----------------------------------------------------------------------------
// linear_prime_sieve
// Linear sieve building a smallest-prime-factor table, one integer per
// transaction, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  item     in   valid/ready     number
//  result   out  valid/ready     smallest_factor, is_prime, primes_found, status
//  limit    in   limit_we        limit_wdata
//
//  a flagged item steps through accept, check, emit; others through accept,
//  check, self, then fetch, mul, mark per prime walked and a last fetch if
//  the walk runs off the end of the prime list; each walk pass reads one
//  prime list entry and marks at most one table entry; after reset the factor
//  table is swept to zero with item.ready low, limit writes taken throughout
//  the result register lets the next item be taken while a result waits;
//  the sequencer holds in its emit step only while that register is full
// ----------------------------------------------------------------------------
module linear_prime_sieve #(
	parameter int MAX_NUMBER  = lps_pkg::MAX_NUMBER_DEF,
	parameter int PRIME_SLOTS = lps_pkg::PRIME_SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	lps_in_if.sink                   item,
	lps_out_if.source                result,
	input  logic                     limit_we,
	input  logic [lps_pkg::NUM_W-1:0] limit_wdata
);
	import lps_pkg::*;

	localparam int AW  = $clog2(MAX_NUMBER + 1);
	localparam int CW  = (AW > NUM_W) ? AW : NUM_W;
	localparam int PRW = 2 * NUM_W;
	localparam int EXW = NUM_W + 1;
	localparam int PW  = $clog2(PRIME_SLOTS);
	localparam int TW  = $clog2(PRIME_SLOTS + 1);

	// configuration and control state
	logic [NUM_W-1:0] limit_q;
	logic             clr_q;
	logic [AW-1:0]    clr_addr_q;
	logic [EXW-1:0]   expected_q;
	logic [TW-1:0]    total_q;
	logic [TW-1:0]    k_q;
	logic             out_valid_q;

	// working registers of the current item
	logic [NUM_W-1:0] num_q;
	status_t          status_q;
	logic             prime_q;
	logic [NUM_W-1:0] self_q;
	logic [NUM_W-1:0] p_q;
	logic [PRW-1:0]   prod_q;

	// result register
	logic [NUM_W-1:0] out_factor_q;
	logic             out_prime_q;
	logic [CNT_W-1:0] out_count_q;
	status_t          out_status_q;

	act_t   act;
	flags_t flags;

	logic [CW-1:0]       lim_eff;
	logic [PRW-1:0]      lim_prod;
	status_t             in_status;
	logic                in_txn;
	logic                over;
	logic                load_out;
	logic                pl_full;
	logic                self_new;
	logic [TW+CNT_W-1:0] cnt_ext;

	logic             ft_we;
	logic [AW-1:0]    ft_waddr;
	logic [NUM_W-1:0] ft_wdata;
	logic [NUM_W-1:0] ft_rdata;
	logic             pl_we;
	logic [NUM_W-1:0] pl_rdata;

	lps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.act    (act)
	);

	// smallest-prime-factor table
	lps_ram #(
		.WIDTH (NUM_W),
		.DEPTH (MAX_NUMBER + 1)
	) u_factor_ram (
		.clk   (clk),
		.we    (ft_we),
		.waddr (ft_waddr),
		.wdata (ft_wdata),
		.raddr (AW'(num_q)),
		.rdata (ft_rdata)
	);

	// prime list
	lps_ram #(
		.WIDTH (NUM_W),
		.DEPTH (PRIME_SLOTS)
	) u_prime_ram (
		.clk   (clk),
		.we    (pl_we),
		.waddr (total_q[PW-1:0]),
		.wdata (num_q),
		.raddr (k_q[PW-1:0]),
		.rdata (pl_rdata)
	);

	// effective limit and input checks
	assign lim_eff  = (CW'(limit_q) > CW'(MAX_NUMBER)) ? CW'(MAX_NUMBER) : CW'(limit_q);
	assign lim_prod = PRW'(lim_eff);
	always_comb begin
		if (CW'(item.number) > lim_eff) begin
			in_status = STAT_RANGE;
		end else if (EXW'(item.number) != expected_q) begin
			in_status = STAT_ORDER;
		end else begin
			in_status = STAT_OK;
		end
	end

	// handshake and sequencer flags
	assign item.ready     = (act == ACT_ACCEPT) && !clr_q;
	assign in_txn         = item.valid && item.ready;
	assign over           = prod_q > lim_prod;
	assign pl_full        = total_q == TW'(PRIME_SLOTS);
	assign self_new       = ft_rdata == '0;
	assign load_out       = (act == ACT_EMIT) && (!out_valid_q || result.ready);
	assign flags.no_txn   = !in_txn;
	assign flags.err      = status_q != STAT_OK;
	assign flags.kdone    = k_q >= total_q;
	assign flags.stop     = over || (p_q == self_q);
	assign flags.out_busy = out_valid_q && !result.ready;

	// table write source: clearing sweep, new prime, or marked product
	always_comb begin
		ft_we    = 1'b0;
		ft_waddr = clr_addr_q;
		ft_wdata = '0;
		if (clr_q) begin
			ft_we = 1'b1;
		end else if (act == ACT_SELF && self_new) begin
			ft_we    = 1'b1;
			ft_waddr = AW'(num_q);
			ft_wdata = num_q;
		end else if (act == ACT_MARK && !over) begin
			ft_we    = 1'b1;
			ft_waddr = AW'(prod_q);
			ft_wdata = p_q;
		end
	end

	assign pl_we = (act == ACT_SELF) && self_new && !pl_full;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_NUMBER)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// sieve control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= EXW'(2);
			total_q    <= '0;
			k_q        <= '0;
		end else begin
			case (act)
				ACT_SELF: begin
					expected_q <= EXW'(num_q) + EXW'(1);
					k_q        <= '0;
					if (self_new && !pl_full) begin
						total_q <= total_q + TW'(1);
					end
				end
				ACT_MARK: begin
					k_q <= k_q + TW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		case (act)
			ACT_ACCEPT: begin
				if (in_txn) begin
					num_q    <= item.number;
					status_q <= in_status;
					prime_q  <= 1'b0;
				end
			end
			ACT_SELF: begin
				self_q  <= self_new ? num_q : ft_rdata;
				prime_q <= self_new;
			end
			ACT_MUL: begin
				p_q    <= pl_rdata;
				prod_q <= PRW'(num_q) * PRW'(pl_rdata);
			end
			default: begin
			end
		endcase
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	assign cnt_ext = {{CNT_W{1'b0}}, total_q};
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_factor_q <= (status_q == STAT_OK) ? self_q : '0;
			out_prime_q  <= (status_q == STAT_OK) && prime_q;
			out_count_q  <= cnt_ext[CNT_W-1:0];
			out_status_q <= status_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.smallest_factor = out_factor_q;
	assign result.is_prime        = out_prime_q;
	assign result.primes_found    = out_count_q;
	assign result.status          = out_status_q;

	// no item taken during the clearing sweep
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !item.ready)
		else $error("item accepted during table clear");

	// prime count never passes the list size
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(PRIME_SLOTS))
		else $error("prime count beyond list size");

	// a marked product lies within the limit
	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!clr_q && act == ACT_MARK && ft_we) |-> (prod_q <= lim_prod))
		else $error("product marked beyond limit");

	// flagged results carry no factor, good results a nonzero one
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status != STAT_OK) |->
			(result.smallest_factor == '0 && !result.is_prime))
		else $error("flagged result carries a factor");

	a_ok_factor: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == STAT_OK) |-> (result.smallest_factor != '0))
		else $error("good result without factor");
endmodule
